### src/tcss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcss_pkg
// Shared types and constants of the textured wall column address generator.
// ----------------------------------------------------------------------------
package tcss_pkg;

    localparam int BYTES_PER_PIXEL_DEF = 4;
    localparam int FRACTION_BITS_DEF   = 16;

    localparam int ROW_W      = 12;
    localparam int HEIGHT_W   = 16;
    localparam int SH_W       = 13;
    localparam int TH_W       = 13;
    localparam int RB_W       = 16;
    localparam int ADDR_W     = 32;
    localparam int FACE_W     = 2;
    localparam int NUM_FACES  = 4;
    localparam int STEP_W     = 32;
    localparam int POS_W      = 48;
    localparam int DIFF_W     = 17;
    localparam int QUEUE_DEPTH = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 64;

    localparam logic [SH_W-1:0] SCREEN_HEIGHT_RST = 13'd480;
    localparam logic [RB_W-1:0] FB_ROW_BYTES_RST  = 16'd2560;
    localparam logic [TH_W-1:0] TEX_HEIGHT_RST    = 13'd64;
    localparam logic [RB_W-1:0] TEX_ROW_BYTES_RST = 16'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN_HEIGHT = 3'd0,
        CFG_FB_ROW_BYTES  = 3'd1,
        CFG_TEX_HEIGHT    = 3'd2,
        CFG_TEX_ROW_BYTES = 3'd3,
        CFG_NORTH_BASE    = 3'd4,
        CFG_EAST_BASE     = 3'd5,
        CFG_WEST_BASE     = 3'd6,
        CFG_SOUTH_BASE    = 3'd7
    } t_cfg_idx;

    typedef enum logic {
        OP_SETUP = 1'b0,
        OP_PIXEL = 1'b1
    } t_op;

    typedef enum logic [FACE_W-1:0] {
        FACE_NORTH = 2'd0,
        FACE_EAST  = 2'd1,
        FACE_WEST  = 2'd2,
        FACE_SOUTH = 2'd3
    } t_face;

    typedef struct packed {
        logic [SH_W-1:0]                  screen_height;
        logic [RB_W-1:0]                  fb_row_bytes;
        logic [TH_W-1:0]                  tex_height;
        logic [RB_W-1:0]                  tex_row_bytes;
        logic [NUM_FACES-1:0][ADDR_W-1:0] face_base;
    } t_cfg;

    typedef struct packed {
        t_op                       op;
        logic [ROW_W-1:0]          column;
        logic [ROW_W-1:0]          span_start;
        logic [ROW_W-1:0]          span_end;
        logic [HEIGHT_W-1:0]       height;     // never zero
        logic [ROW_W-1:0]          texel_col;
        t_face                     face;
        logic signed [DIFF_W-1:0]  diff;       // span_start - wall top
    } t_item;

endpackage

### src/texture_column_span_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texture_column_span_sampler
// Address generator for one textured wall column of a raycaster.
// ----------------------------------------------------------------------------
// A setup item (tuser = 0) latches a column span and computes the Q-format
// texture step with a restoring divider that yields one quotient bit per
// cycle; the setup holds the span engine while it runs and gives no result.
// Pixel items (tuser = 1) stream at one per cycle while the output is not
// stalled and no setup is busy, and each yields one framebuffer offset /
// texel address pair through the input register, the four-item queue, the
// stage-1 register and the output register; pixel items with no active span
// are dropped. Items queue behind a setup while its divide runs.
// Configuration must be written only while idle; it is not enforced.
// ----------------------------------------------------------------------------
module texture_column_span_sampler #(
    parameter int BYTES_PER_PIXEL = tcss_pkg::BYTES_PER_PIXEL_DEF,
    parameter int FRACTION_BITS   = tcss_pkg::FRACTION_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave: column_x, span_start, span_end, wall_height, texel_column, face
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [tcss_pkg::IN_DATA_W-1:0]      i_s_tdata,
    // slave: opcode
    input  logic [0:0]                          i_s_tuser,
    // master: screen_offset, texel_address
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [tcss_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    output logic                                o_m_tlast,
    input  logic                                i_cfg_we,
    input  logic [tcss_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tcss_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int DVD_W = tcss_pkg::TH_W + FRACTION_BITS;

    tcss_pkg::t_cfg                  r_cfg;
    logic                            front_push;
    tcss_pkg::t_item                 front_item;
    logic                            q_full;
    logic                            q_valid;
    logic                            q_pop;
    tcss_pkg::t_item                 q_item;
    logic                            div_start;
    logic [DVD_W-1:0]                div_dividend;
    logic [tcss_pkg::HEIGHT_W-1:0]   div_divisor;
    logic                            div_done;
    logic [DVD_W-1:0]                div_quotient;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.screen_height <= tcss_pkg::SCREEN_HEIGHT_RST;
            r_cfg.fb_row_bytes  <= tcss_pkg::FB_ROW_BYTES_RST;
            r_cfg.tex_height    <= tcss_pkg::TEX_HEIGHT_RST;
            r_cfg.tex_row_bytes <= tcss_pkg::TEX_ROW_BYTES_RST;
            r_cfg.face_base     <= '0;
        end else if (i_cfg_we) begin
            case (tcss_pkg::t_cfg_idx'(i_cfg_index))
                tcss_pkg::CFG_SCREEN_HEIGHT:
                    r_cfg.screen_height <= i_cfg_data[tcss_pkg::SH_W-1:0];
                tcss_pkg::CFG_FB_ROW_BYTES:
                    r_cfg.fb_row_bytes <= i_cfg_data[tcss_pkg::RB_W-1:0];
                tcss_pkg::CFG_TEX_HEIGHT:
                    r_cfg.tex_height <= i_cfg_data[tcss_pkg::TH_W-1:0];
                tcss_pkg::CFG_TEX_ROW_BYTES:
                    r_cfg.tex_row_bytes <= i_cfg_data[tcss_pkg::RB_W-1:0];
                tcss_pkg::CFG_NORTH_BASE:
                    r_cfg.face_base[tcss_pkg::FACE_NORTH] <= i_cfg_data;
                tcss_pkg::CFG_EAST_BASE:
                    r_cfg.face_base[tcss_pkg::FACE_EAST] <= i_cfg_data;
                tcss_pkg::CFG_WEST_BASE:
                    r_cfg.face_base[tcss_pkg::FACE_WEST] <= i_cfg_data;
                tcss_pkg::CFG_SOUTH_BASE:
                    r_cfg.face_base[tcss_pkg::FACE_SOUTH] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    tcss_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (i_s_tvalid),
        .o_s_tready      (o_s_tready),
        .i_s_tdata       (i_s_tdata),
        .i_s_tuser       (i_s_tuser[0]),
        .i_screen_height (r_cfg.screen_height),
        .i_full          (q_full),
        .o_push          (front_push),
        .o_item          (front_item)
    );

    tcss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    tcss_divider #(
        .DVD_W (DVD_W)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    tcss_back #(
        .BYTES_PER_PIXEL (BYTES_PER_PIXEL),
        .FRACTION_BITS   (FRACTION_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_valid      (q_valid),
        .i_q_item       (q_item),
        .o_q_pop        (q_pop),
        .o_div_start    (div_start),
        .o_div_dividend (div_dividend),
        .o_div_divisor  (div_divisor),
        .i_div_done     (div_done),
        .i_div_quotient (div_quotient),
        .o_m_tvalid     (o_m_tvalid),
        .i_m_tready     (i_m_tready),
        .o_m_tdata      (o_m_tdata),
        .o_m_tlast      (o_m_tlast)
    );

endmodule

### src/tcss_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcss_front
// Input stage: takes items, unpacks and classifies them, precomputes the
// span start offset from the wall top and hands them to the queue.
// ----------------------------------------------------------------------------
module tcss_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [tcss_pkg::IN_DATA_W-1:0]       i_s_tdata,
    input  logic                                 i_s_tuser,
    input  logic [tcss_pkg::SH_W-1:0]            i_screen_height,
    input  logic                                 i_full,
    output logic                                 o_push,
    output tcss_pkg::t_item                      o_item
);

    localparam int COL_LSB   = 0;
    localparam int START_LSB = COL_LSB + tcss_pkg::ROW_W;
    localparam int END_LSB   = START_LSB + tcss_pkg::ROW_W;
    localparam int H_LSB     = END_LSB + tcss_pkg::ROW_W;
    localparam int TEX_LSB   = H_LSB + tcss_pkg::HEIGHT_W;
    localparam int FACE_LSB  = TEX_LSB + tcss_pkg::ROW_W;

    logic                            r_valid;
    tcss_pkg::t_item                 r_item;
    tcss_pkg::t_item                 n_item;
    logic [tcss_pkg::HEIGHT_W-1:0]   height_raw;
    logic [tcss_pkg::HEIGHT_W-1:0]   height_fix;
    logic [tcss_pkg::DIFF_W-1:0]     diff_raw;

    assign height_raw = i_s_tdata[H_LSB +: tcss_pkg::HEIGHT_W];
    assign height_fix = (height_raw == '0) ? tcss_pkg::HEIGHT_W'(1) : height_raw;

    // start - (screen_height/2 - height/2); the true value fits DIFF_W signed
    assign diff_raw = tcss_pkg::DIFF_W'(i_s_tdata[START_LSB +: tcss_pkg::ROW_W])
                    - tcss_pkg::DIFF_W'(i_screen_height[tcss_pkg::SH_W-1:1])
                    + tcss_pkg::DIFF_W'(height_fix[tcss_pkg::HEIGHT_W-1:1]);

    always_comb begin
        n_item            = '0;
        n_item.op         = tcss_pkg::t_op'(i_s_tuser);
        n_item.column     = i_s_tdata[COL_LSB +: tcss_pkg::ROW_W];
        n_item.span_start = i_s_tdata[START_LSB +: tcss_pkg::ROW_W];
        n_item.span_end   = i_s_tdata[END_LSB +: tcss_pkg::ROW_W];
        n_item.height     = height_fix;
        n_item.texel_col  = i_s_tdata[TEX_LSB +: tcss_pkg::ROW_W];
        n_item.face       = tcss_pkg::t_face'(i_s_tdata[FACE_LSB +: tcss_pkg::FACE_W]);
        n_item.diff       = $signed(diff_raw);
    end

    assign o_s_tready = !r_valid || !i_full;
    assign o_push     = r_valid && !i_full;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_item <= n_item;
        end
    end

endmodule

### src/tcss_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcss_queue
// Short item queue between the input stage and the span engine.
// ----------------------------------------------------------------------------
module tcss_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tcss_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output tcss_pkg::t_item o_item
);

    localparam int PTR_W = $clog2(tcss_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(tcss_pkg::QUEUE_DEPTH + 1);

    tcss_pkg::t_item   r_mem [tcss_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == CNT_W'(tcss_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

### src/tcss_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcss_divider
// Restoring divider, one quotient bit per cycle, for the texture step.
// ----------------------------------------------------------------------------
module tcss_divider #(
    parameter int DVD_W = tcss_pkg::TH_W + tcss_pkg::FRACTION_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [DVD_W-1:0]               i_dividend,
    input  logic [tcss_pkg::HEIGHT_W-1:0]  i_divisor,
    output logic                           o_done,
    output logic [DVD_W-1:0]               o_quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);
    localparam int DV_W  = tcss_pkg::HEIGHT_W;

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DVD_W-1:0]  r_work;
    logic [DV_W-1:0]   r_rem;
    logic [DV_W-1:0]   r_div;
    logic [DV_W:0]     rem_sh;
    logic              ge;
    logic [DV_W:0]     rem_sub;

    assign rem_sh  = {r_rem, r_work[DVD_W-1]};
    assign ge      = (rem_sh >= {1'b0, r_div});
    assign rem_sub = rem_sh - {1'b0, r_div};

    assign o_done     = r_done;
    assign o_quotient = r_work;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            // remainder stays below the divisor, so DV_W bits hold it
            r_rem  <= ge ? rem_sub[DV_W-1:0] : rem_sh[DV_W-1:0];
            r_work <= {r_work[DVD_W-2:0], ge};
        end
    end

endmodule

### src/tcss_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcss_back
// Span engine: runs setup items through the step divide and start position
// multiply, and turns pixel items into framebuffer and texel addresses
// through a two-stage pipeline whose second stage is the output register.
// ----------------------------------------------------------------------------
module tcss_back #(
    parameter int BYTES_PER_PIXEL = tcss_pkg::BYTES_PER_PIXEL_DEF,
    parameter int FRACTION_BITS   = tcss_pkg::FRACTION_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  tcss_pkg::t_cfg                       i_cfg,
    input  logic                                 i_q_valid,
    input  tcss_pkg::t_item                      i_q_item,
    output logic                                 o_q_pop,
    output logic                                 o_div_start,
    output logic [tcss_pkg::TH_W+FRACTION_BITS-1:0] o_div_dividend,
    output logic [tcss_pkg::HEIGHT_W-1:0]        o_div_divisor,
    input  logic                                 i_div_done,
    input  logic [tcss_pkg::TH_W+FRACTION_BITS-1:0] i_div_quotient,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [tcss_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    output logic                                 o_m_tlast
);

    localparam int DVD_W  = tcss_pkg::TH_W + FRACTION_BITS;
    localparam int STEP_W = tcss_pkg::STEP_W;
    localparam int POS_W  = tcss_pkg::POS_W;
    localparam int QX_W   = (DVD_W > STEP_W) ? DVD_W : STEP_W + 1;
    localparam int PROD_W = tcss_pkg::DIFF_W + STEP_W + 1;
    localparam int RI_W   = POS_W - FRACTION_BITS;
    localparam int BPP_W  = $clog2(BYTES_PER_PIXEL + 1);
    localparam int COLB_W = tcss_pkg::ROW_W + BPP_W;
    localparam int SP_W   = tcss_pkg::ROW_W + tcss_pkg::RB_W;
    localparam int TP_W   = tcss_pkg::TH_W + tcss_pkg::RB_W;
    localparam int ADDR_W = tcss_pkg::ADDR_W;
    localparam int TH_W   = tcss_pkg::TH_W;
    localparam int ROW_W  = tcss_pkg::ROW_W;

    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    typedef enum logic [2:0] {
        S_RUN = 3'b001,
        S_DIV = 3'b010,
        S_MUL = 3'b100
    } t_state;

    t_state                           r_state;
    logic                             r_active;
    logic [ROW_W-1:0]                 r_cur_row;
    logic [ROW_W-1:0]                 r_final_row;
    logic [ROW_W-1:0]                 r_column;
    logic [ROW_W-1:0]                 r_texel_col;
    tcss_pkg::t_face                  r_face;
    logic [STEP_W-1:0]                r_step;
    logic signed [POS_W-1:0]          r_pos;
    logic signed [tcss_pkg::DIFF_W-1:0] r_diff;

    logic                             r_s1_valid;
    logic [SP_W-1:0]                  r_s1_screen_prod;
    logic [COLB_W-1:0]                r_s1_colb;
    logic [TP_W-1:0]                  r_s1_tex_prod;
    logic [COLB_W-1:0]                r_s1_texb;
    logic [ADDR_W-1:0]                r_s1_base;
    logic                             r_s1_last;

    logic                             r_out_valid;
    logic [ADDR_W-1:0]                r_out_screen;
    logic [ADDR_W-1:0]                r_out_texel;
    logic                             r_out_last;

    logic                             adv;
    logic                             head_setup;
    logic                             head_pixel;
    logic                             pop_setup;
    logic                             pop_pixel;
    logic                             emit;
    logic                             is_last;
    logic [RI_W-1:0]                  row_int;
    logic [TH_W-1:0]                  tex_row;
    logic [POS_W:0]                   pos_sum;
    logic signed [POS_W-1:0]          pos_next;
    logic signed [PROD_W-1:0]         start_prod;
    logic signed [POS_W-1:0]          start_pos;
    logic [QX_W-1:0]                  quot_ext;
    logic [STEP_W-1:0]                step_sat;
    logic [ADDR_W-1:0]                n_out_screen;
    logic [ADDR_W-1:0]                n_out_texel;

    assign adv        = !r_out_valid || i_m_tready;
    assign head_setup = i_q_valid && (i_q_item.op == tcss_pkg::OP_SETUP);
    assign head_pixel = i_q_valid && (i_q_item.op == tcss_pkg::OP_PIXEL);
    assign pop_setup  = (r_state == S_RUN) && head_setup;
    assign pop_pixel  = (r_state == S_RUN) && head_pixel && adv;
    assign emit       = pop_pixel && r_active;
    assign is_last    = (r_cur_row == r_final_row);
    assign o_q_pop    = pop_setup || pop_pixel;

    assign o_div_start    = pop_setup;
    assign o_div_dividend = {i_cfg.tex_height, {FRACTION_BITS{1'b0}}};
    assign o_div_divisor  = i_q_item.height;

    // saturate the quotient to the step width
    assign quot_ext = QX_W'(i_div_quotient);
    assign step_sat = (|quot_ext[QX_W-1:STEP_W]) ? {STEP_W{1'b1}} : quot_ext[STEP_W-1:0];

    // start position = diff * step, saturated to the signed position range
    assign start_prod = PROD_W'(r_diff) * PROD_W'($signed({1'b0, r_step}));
    always_comb begin
        if ((&start_prod[PROD_W-1:POS_W-1]) || !(|start_prod[PROD_W-1:POS_W-1])) begin
            start_pos = start_prod[POS_W-1:0];
        end else if (start_prod[PROD_W-1]) begin
            start_pos = POS_MIN;
        end else begin
            start_pos = POS_MAX;
        end
    end

    // advance by one step; the step is never negative
    assign pos_sum = {r_pos[POS_W-1], r_pos} + (POS_W + 1)'(r_step);
    always_comb begin
        if (pos_sum[POS_W] != pos_sum[POS_W-1]) begin
            pos_next = pos_sum[POS_W] ? POS_MIN : POS_MAX;
        end else begin
            pos_next = pos_sum[POS_W-1:0];
        end
    end

    // texel row: negative reads row 0, past the end clamps to the last row
    assign row_int = r_pos[POS_W-1:FRACTION_BITS];
    always_comb begin
        if (r_pos[POS_W-1]) begin
            tex_row = '0;
        end else if (row_int >= RI_W'(i_cfg.tex_height)) begin
            tex_row = (i_cfg.tex_height == '0) ? '0 : i_cfg.tex_height - TH_W'(1);
        end else begin
            tex_row = row_int[TH_W-1:0];
        end
    end

    assign n_out_screen = ADDR_W'(r_s1_screen_prod) + ADDR_W'(r_s1_colb);
    assign n_out_texel  = r_s1_base + ADDR_W'(r_s1_tex_prod) + ADDR_W'(r_s1_texb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_active    <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_RUN: begin
                    if (pop_setup) begin
                        r_active <= (i_q_item.span_start <= i_q_item.span_end);
                        r_state  <= S_DIV;
                    end else if (emit && is_last) begin
                        r_active <= 1'b0;
                    end
                end
                S_DIV: begin
                    if (i_div_done) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_RUN;
                end
                default: begin
                    r_state <= S_RUN;
                end
            endcase
            if (adv) begin
                r_s1_valid  <= emit;
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop_setup) begin
            r_column    <= i_q_item.column;
            r_texel_col <= i_q_item.texel_col;
            r_face      <= i_q_item.face;
            r_cur_row   <= i_q_item.span_start;
            r_final_row <= i_q_item.span_end;
            r_diff      <= i_q_item.diff;
        end else if (emit) begin
            r_pos <= pos_next;
            if (!is_last) begin
                r_cur_row <= r_cur_row + ROW_W'(1);
            end
        end
        if ((r_state == S_DIV) && i_div_done) begin
            r_step <= step_sat;
        end
        if (r_state == S_MUL) begin
            r_pos <= start_pos;
        end
        if (emit) begin
            r_s1_screen_prod <= SP_W'(r_cur_row) * SP_W'(i_cfg.fb_row_bytes);
            r_s1_colb        <= COLB_W'(r_column) * COLB_W'(BYTES_PER_PIXEL);
            r_s1_tex_prod    <= TP_W'(tex_row) * TP_W'(i_cfg.tex_row_bytes);
            r_s1_texb        <= COLB_W'(r_texel_col) * COLB_W'(BYTES_PER_PIXEL);
            r_s1_base        <= i_cfg.face_base[r_face];
            r_s1_last        <= is_last;
        end
        if (adv && r_s1_valid) begin
            r_out_screen <= n_out_screen;
            r_out_texel  <= n_out_texel;
            r_out_last   <= r_s1_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_texel, r_out_screen};
    assign o_m_tlast  = r_out_last;

endmodule

### src/tcss_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcss_checker
// Port-level checks of the wall column address generator.
// ----------------------------------------------------------------------------
module tcss_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_s_tready,
    input logic                                o_m_tvalid,
    input logic                                i_m_tready,
    input logic [tcss_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    input logic                                o_m_tlast
);

    // a stalled result holds its value and last flag
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tlast))
        else $error("result changed while stalled");

    // reset flushes the result pipeline
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // reset empties the input stage and queue, so input is taken at once
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_tready)
        else $error("input not ready right after reset");

endmodule

bind texture_column_span_sampler tcss_checker u_tcss_checker (.*);

### tb/texture_column_span_sampler_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texture_column_span_sampler_test
// Self-checking bench for the textured wall column address generator.
// ----------------------------------------------------------------------------
// A short directed script runs at the reset settings: idle pixels, empty and
// replaced spans, a zero wall height and a span that starts above the texture
// top. Random phases follow, each under its own register settings (minimums,
// maximums and a zero texture height among them). Most random traffic is a
// setup followed by the pixels of its span, some cut short or overrun; the
// rest is stray setups and pixels. A behavioral model of the span walk
// predicts each address the script does not give; the result stream is
// compared in order. Both sides idle at random, one side not in some phases.
// ----------------------------------------------------------------------------
module texture_column_span_sampler_test;

    localparam int BPP       = tcss_pkg::BYTES_PER_PIXEL_DEF;
    localparam int FRAC      = tcss_pkg::FRACTION_BITS_DEF;
    localparam int STALL_MAX = 16;
    localparam int SETTLE    = 256;      // five queued setups plus one dividing, with margin
    localparam int PRINT_MAX = 100;
    localparam int N_SCRIPT  = 24;
    localparam int N_PHASES  = 8;
    localparam int PHASE_ITEMS = 110;
    localparam longint POS_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint POS_LO = -POS_HI - 1;

    // Input fields, column_x in the lowest bits
    typedef struct packed {
        logic [1:0]  face;
        logic [11:0] texel_column;
        logic [15:0] wall_height;
        logic [11:0] span_end;
        logic [11:0] span_start;
        logic [11:0] column_x;
    } t_column_req;

    typedef struct packed {
        logic        last;
        logic [31:0] texel_address;
        logic [31:0] screen_offset;
    } t_pixel_addr;

    typedef struct {
        tcss_pkg::t_op   op;
        logic [11:0]     col;
        logic [11:0]     span_first;
        logic [11:0]     span_stop;
        logic [15:0]     height;
        logic [11:0]     tcol;
        tcss_pkg::t_face face;
        bit              typed;
        bit              has_px;
        logic [31:0]     soff;
        logic [31:0]     taddr;
        bit              last;
    } t_script_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [tcss_pkg::IN_DATA_W-1:0] i_s_tdata = '0;   // column_x, span_start, span_end,
                                                      // wall_height, texel_column, face
    logic [0:0]  i_s_tuser = '0;                      // opcode
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [tcss_pkg::OUT_DATA_W-1:0] o_m_tdata;       // screen_offset, texel_address
    logic        o_m_tlast;
    logic        i_cfg_we = 1'b0;
    logic [tcss_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [tcss_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    texture_column_span_sampler DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Predictor copy of the registers and the span walk
    logic [12:0]        rows_on_screen = 13'd480;
    logic [15:0]        fb_pitch       = 16'd2560;
    logic [12:0]        tex_rows       = 13'd64;
    logic [15:0]        tex_pitch      = 16'd256;
    logic [31:0]        tex_base [tcss_pkg::NUM_FACES] = '{default: 32'd0};
    bit                 span_on        = 1'b0;
    logic [11:0]        row_now        = '0;
    logic [11:0]        row_last       = '0;
    logic [11:0]        col_slice      = '0;
    logic [11:0]        tcol_slice     = '0;
    tcss_pkg::t_face    face_slice     = tcss_pkg::FACE_NORTH;
    logic [31:0]        tex_step       = '0;
    logic signed [47:0] tex_pos        = '0;

    t_pixel_addr expected_px[$];
    int          mismatches = 0;
    bit          sender_calm = 1'b0;
    bit          sink_calm = 1'b0;

    t_script_row script [N_SCRIPT] = '{
        '{tcss_pkg::OP_PIXEL, 0, 0, 0, 0, 0, tcss_pkg::FACE_NORTH, 1, 0, 0, 0, 0},
        '{tcss_pkg::OP_SETUP, 0, 0, 0, 480, 0, tcss_pkg::FACE_NORTH, 1, 0, 0, 0, 0},
        '{tcss_pkg::OP_PIXEL, 0, 0, 0, 0, 0, tcss_pkg::FACE_NORTH, 1, 1, 0, 0, 1},
        '{tcss_pkg::OP_PIXEL, 0, 0, 0, 0, 0, tcss_pkg::FACE_NORTH, 1, 0, 0, 0, 0},
        // zero wall height, every field at its top value
        '{tcss_pkg::OP_SETUP, 4095, 4095, 4095, 0, 4095, tcss_pkg::FACE_SOUTH, 1, 0, 0, 0, 0},
        '{tcss_pkg::OP_PIXEL, 0, 0, 0, 0, 0, tcss_pkg::FACE_NORTH, 1, 1, 10499580, 32508, 1},
        // empty span, then a pixel with nothing to draw
        '{tcss_pkg::OP_SETUP, 7, 5, 4, 100, 9, tcss_pkg::FACE_EAST, 1, 0, 0, 0, 0},
        '{tcss_pkg::OP_PIXEL, 0, 0, 0, 0, 0, tcss_pkg::FACE_NORTH, 1, 0, 0, 0, 0},
        // span starts above the wall top: texture position negative
        '{tcss_pkg::OP_SETUP, 1, 0, 3, 10, 2, tcss_pkg::FACE_EAST, 1, 0, 0, 0, 0},
        '{tcss_pkg::OP_PIXEL, 0, 0, 0, 0, 0, tcss_pkg::FACE_NORTH, 1, 1, 4, 8, 0},
        '{tcss_pkg::OP_PIXEL, 0, 0, 0, 0, 0, tcss_pkg::FACE_NORTH, 1, 1, 2564, 8, 0},
        // replace the active span
        '{tcss_pkg::OP_SETUP, 100, 230, 250, 20, 31, tcss_pkg::FACE_WEST, 0, 0, 0, 0, 0},
        '{tcss_pkg::OP_PIXEL, 0, 0, 0, 0, 0, tcss_pkg::FACE_NORTH, 0, 0, 0, 0, 0},
        '{tcss_pkg::OP_PIXEL, 0, 0, 0, 0, 0, tcss_pkg::FACE_NORTH, 0, 0, 0, 0, 0},
        '{tcss_pkg::OP_PIXEL, 0, 0, 0, 0, 0, tcss_pkg::FACE_NORTH, 0, 0, 0, 0, 0},
        '{tcss_pkg::OP_PIXEL, 0, 0, 0, 0, 0, tcss_pkg::FACE_NORTH, 0, 0, 0, 0, 0},
        '{tcss_pkg::OP_SETUP, 2048, 2040, 2047, 65535, 2048, tcss_pkg::FACE_WEST,
          0, 0, 0, 0, 0},
        '{tcss_pkg::OP_PIXEL, 0, 0, 0, 0, 0, tcss_pkg::FACE_NORTH, 0, 0, 0, 0, 0},
        '{tcss_pkg::OP_PIXEL, 0, 0, 0, 0, 0, tcss_pkg::FACE_NORTH, 0, 0, 0, 0, 0},
        '{tcss_pkg::OP_PIXEL, 0, 0, 0, 0, 0, tcss_pkg::FACE_NORTH, 0, 0, 0, 0, 0},
        '{tcss_pkg::OP_SETUP, 1, 100, 101, 1, 1, tcss_pkg::FACE_EAST, 0, 0, 0, 0, 0},
        '{tcss_pkg::OP_PIXEL, 0, 0, 0, 0, 0, tcss_pkg::FACE_NORTH, 0, 0, 0, 0, 0},
        '{tcss_pkg::OP_PIXEL, 0, 0, 0, 0, 0, tcss_pkg::FACE_NORTH, 0, 0, 0, 0, 0},
        '{tcss_pkg::OP_PIXEL, 0, 0, 0, 0, 0, tcss_pkg::FACE_NORTH, 0, 0, 0, 0, 0}
    };

    function automatic logic signed [47:0] clamp_pos(input longint v);
        if (v > POS_HI)
            return 48'(POS_HI);
        if (v < POS_LO)
            return 48'(POS_LO);
        return 48'(v);
    endfunction

    // Advance the span walk by one item and work out its pixel addresses
    task automatic walk_span(input tcss_pkg::t_op op, input t_column_req f,
                             output bit emitted, output t_pixel_addr px);
        logic [16:0]       h;
        longint unsigned   quot;
        longint            top;
        longint            diff;
        longint            tex_row;
        logic [31:0]       row_sel;
        bit                at_end;
        emitted = 1'b0;
        px = '0;
        if (op == tcss_pkg::OP_SETUP) begin
            h = (f.wall_height == 16'd0) ? 17'd1 : {1'b0, f.wall_height};
            quot = (longint'(tex_rows) << FRAC) / longint'(h);
            tex_step = (quot > 64'hFFFF_FFFF) ? '1 : quot[31:0];
            top = longint'(rows_on_screen / 13'd2) - longint'(h / 17'd2);
            diff = longint'(f.span_start) - top;
            tex_pos = clamp_pos(diff * longint'(tex_step));
            col_slice = f.column_x;
            tcol_slice = f.texel_column;
            face_slice = tcss_pkg::t_face'(f.face);
            row_now = f.span_start;
            row_last = f.span_end;
            span_on = f.span_start <= f.span_end;
        end else if (span_on) begin
            at_end = row_now == row_last;
            if (tex_pos < 0) begin
                row_sel = 32'd0;
            end else begin
                tex_row = longint'(tex_pos) >> FRAC;
                if (tex_row >= longint'(tex_rows))
                    row_sel = (tex_rows == 13'd0) ? 32'd0 : 32'(tex_rows) - 32'd1;
                else
                    row_sel = 32'(tex_row);
            end
            px.screen_offset = 32'(row_now) * 32'(fb_pitch) + 32'(col_slice) * 32'(BPP);
            px.texel_address = tex_base[face_slice] + row_sel * 32'(tex_pitch)
                             + 32'(tcol_slice) * 32'(BPP);
            px.last = at_end;
            emitted = 1'b1;
            tex_pos = clamp_pos(longint'(tex_pos) + longint'(tex_step));
            if (at_end)
                span_on = 1'b0;
            else
                row_now = row_now + 12'd1;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < PRINT_MAX)
            $display("%0t mismatch %s: got %h, want %h", $time, what, got, want);
        mismatches++;
    endtask

    // Called at a falling edge; returns at a falling edge with tvalid still high
    task automatic send_item(input tcss_pkg::t_op op, input t_column_req f, input bit typed,
                             input bit typed_has, input t_pixel_addr typed_px,
                             output bit counted);
        int          gap;
        bit          emitted;
        t_pixel_addr px;
        gap = sender_calm ? 0 : ($urandom_range(0, 1) ? 0 : $urandom_range(0, STALL_MAX));
        if (gap > 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata = {6'b0, f};
        i_s_tuser = op;
        do @(posedge i_clk); while (!o_s_tready);
        walk_span(op, f, emitted, px);
        if (typed) begin
            if (typed_has)
                expected_px.push_back(typed_px);
        end else if (emitted) begin
            expected_px.push_back(px);
        end
        counted = (op == tcss_pkg::OP_SETUP) || emitted;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_s_tvalid = 1'b0;
        while (expected_px.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input tcss_pkg::t_cfg_idx idx, input logic [31:0] v);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = v;
        case (idx)
            tcss_pkg::CFG_SCREEN_HEIGHT: rows_on_screen = v[12:0];
            tcss_pkg::CFG_FB_ROW_BYTES:  fb_pitch = v[15:0];
            tcss_pkg::CFG_TEX_HEIGHT:    tex_rows = v[12:0];
            tcss_pkg::CFG_TEX_ROW_BYTES: tex_pitch = v[15:0];
            tcss_pkg::CFG_NORTH_BASE:    tex_base[tcss_pkg::FACE_NORTH] = v;
            tcss_pkg::CFG_EAST_BASE:     tex_base[tcss_pkg::FACE_EAST] = v;
            tcss_pkg::CFG_WEST_BASE:     tex_base[tcss_pkg::FACE_WEST] = v;
            tcss_pkg::CFG_SOUTH_BASE:    tex_base[tcss_pkg::FACE_SOUTH] = v;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Wait out every result and any setup still dividing, then rewrite all
    task automatic load_settings(input logic [31:0] sh, input logic [31:0] fbrb,
                                 input logic [31:0] th, input logic [31:0] trb,
                                 input logic [31:0] north, input logic [31:0] east,
                                 input logic [31:0] west, input logic [31:0] south);
        wait_drained();
        repeat (SETTLE) @(negedge i_clk);
        write_reg(tcss_pkg::CFG_SCREEN_HEIGHT, sh);
        write_reg(tcss_pkg::CFG_FB_ROW_BYTES, fbrb);
        write_reg(tcss_pkg::CFG_TEX_HEIGHT, th);
        write_reg(tcss_pkg::CFG_TEX_ROW_BYTES, trb);
        write_reg(tcss_pkg::CFG_NORTH_BASE, north);
        write_reg(tcss_pkg::CFG_EAST_BASE, east);
        write_reg(tcss_pkg::CFG_WEST_BASE, west);
        write_reg(tcss_pkg::CFG_SOUTH_BASE, south);
        i_cfg_we = 1'b0;
    endtask

    function automatic t_column_req junk_req();
        return t_column_req'(66'({$urandom, $urandom, $urandom}));
    endfunction

    task automatic run_phase(input int target);
        int          done;
        int          first_row;
        int          len;
        int          npx;
        t_column_req f;
        bit          c;
        done = 0;
        while (done < target) begin
            if ($urandom_range(0, 39) == 0)
                wait_drained();
            f = junk_req();
            case ($urandom_range(0, 3))
                0: f.wall_height = 16'($urandom_range(0, 65535));
                1: f.wall_height = 16'($urandom_range(0, 15));
                default: f.wall_height = 16'($urandom_range(1, 1024));
            endcase
            if ($urandom_range(0, 9) == 0) begin
                // stray setup with any span, or a stray pixel
                if ($urandom_range(0, 1))
                    send_item(tcss_pkg::OP_SETUP, f, 1'b0, 1'b0, '0, c);
                else
                    send_item(tcss_pkg::OP_PIXEL, f, 1'b0, 1'b0, '0, c);
                done += int'(c);
                continue;
            end
            first_row = $urandom_range(0, 4095);
            f.span_start = 12'(first_row);
            if (first_row > 0 && $urandom_range(0, 9) == 0) begin
                f.span_end = 12'($urandom_range(0, first_row - 1));
                npx = $urandom_range(0, 2);
            end else begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(16, 200)
                                                   : $urandom_range(0, 15);
                if (first_row + len > 4095)
                    len = 4095 - first_row;
                f.span_end = 12'(first_row + len);
                case ($urandom_range(0, 7))
                    0: npx = $urandom_range(0, len);              // cut short
                    1: npx = len + 1 + $urandom_range(1, 3);      // overrun
                    default: npx = len + 1;
                endcase
            end
            send_item(tcss_pkg::OP_SETUP, f, 1'b0, 1'b0, '0, c);
            done += int'(c);
            for (int k = 0; k < npx; k++) begin
                send_item(tcss_pkg::OP_PIXEL, junk_req(), 1'b0, 1'b0, '0, c);
                done += int'(c);
            end
        end
    endtask

    // Result side: draw a stall per item, then hold ready until one is taken
    initial begin
        int stall;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = sink_calm ? 0 : ($urandom_range(0, 1) ? 0 : $urandom_range(0, STALL_MAX));
            if (stall > 0) begin
                i_m_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_tready = 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_pixel_addr want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_px.size() == 0) begin
                report_mismatch("unexpected item", o_m_tdata[31:0], 32'd0);
            end else begin
                want = expected_px.pop_front();
                if (o_m_tdata[31:0] !== want.screen_offset)
                    report_mismatch("screen_offset", o_m_tdata[31:0], want.screen_offset);
                if (o_m_tdata[63:32] !== want.texel_address)
                    report_mismatch("texel_address", o_m_tdata[63:32], want.texel_address);
                if (o_m_tlast !== want.last)
                    report_mismatch("last", 32'(o_m_tlast), 32'(want.last));
            end
        end
    end

    initial begin
        t_column_req f;
        t_pixel_addr px;
        bit          c;
        int          waited;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed script at the reset settings
        for (int i = 0; i < N_SCRIPT; i++) begin
            f = '0;
            f.column_x = script[i].col;
            f.span_start = script[i].span_first;
            f.span_end = script[i].span_stop;
            f.wall_height = script[i].height;
            f.texel_column = script[i].tcol;
            f.face = script[i].face;
            px.screen_offset = script[i].soff;
            px.texel_address = script[i].taddr;
            px.last = script[i].last;
            send_item(script[i].op, f, script[i].typed, script[i].has_px, px, c);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                1: load_settings(1, 4, 1, 4, 0, 0, 0, 0);
                2: load_settings(4096, 65535, 4096, 65535, 32'hFFFF_FFFF,
                                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                3: load_settings($urandom_range(1, 4096), $urandom_range(4, 65535), 0,
                                 $urandom_range(4, 65535), $urandom, $urandom,
                                 $urandom, $urandom);
                default: load_settings($urandom_range(1, 4096), $urandom_range(4, 65535),
                                       $urandom_range(0, 1) ? $urandom_range(1, 128)
                                                            : $urandom_range(1, 4096),
                                       $urandom_range(4, 65535), $urandom, $urandom,
                                       $urandom, $urandom);
            endcase
            sender_calm = (p % 3) == 2;
            sink_calm = (p % 3) == 1;
            run_phase(PHASE_ITEMS);
        end

        i_s_tvalid = 1'b0;
        waited = 0;
        while (expected_px.size() != 0 && waited < 5000) begin
            @(negedge i_clk);
            waited++;
        end
        while (expected_px.size() != 0) begin
            px = expected_px.pop_front();
            report_mismatch("missing item", 32'd0, px.screen_offset);
        end
        repeat (SETTLE) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### texture_column_span_sampler.f
src/tcss_pkg.sv
src/tcss_front.sv
src/tcss_queue.sv
src/tcss_divider.sv
src/tcss_back.sv
src/texture_column_span_sampler.sv
src/tcss_checker.sv
tb/texture_column_span_sampler_test.sv
